// ===== sv/line_keyword_matcher_macros.svh =====
// Assertion macros used by the line keyword matcher checker.
`ifndef LINE_KEYWORD_MATCHER_MACROS_SVH
`define LINE_KEYWORD_MATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LKM_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line keyword matcher check failed");

// Consequent must hold in the cycle after the antecedent.
`define LKM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line keyword matcher check failed");

`endif

// ===== sv/lkm_pkg.sv =====
// Shared types, constants and helper functions of the line keyword matcher.
package lkm_pkg;

	localparam int unsigned KEY_BYTES = 16;
	localparam int unsigned LEN_W     = 24;
	localparam int unsigned NUM_W     = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 64;
	// Entries of the queue between front and back; must be a power of two.
	localparam int unsigned QDEPTH    = 2;

	localparam logic [7:0] CHAR_NL = 8'd10;
	localparam logic [7:0] CHAR_US = 8'd95;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_LO  = 3'd0,
		REG_KEY_HI  = 3'd1,
		REG_KEY_LEN = 3'd2,
		REG_MODE    = 3'd3,
		REG_ICASE   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_SUBSTR = 2'd0,
		MODE_WORD   = 2'd1,
		MODE_LINE   = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_data;
	} in_t;

	typedef struct packed {
		logic [NUM_W-1:0] line_number;
		logic [LEN_W-1:0] line_length;
		logic             line_matched;
	} out_t;

	// Classified byte handed from the front to the back.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       last;
		logic       is_nl;
		logic       is_word;
	} cls_t;

	// One slot of the recent-byte window.
	typedef struct packed {
		logic [7:0] b;
		logic       w;
	} wslot_t;

	typedef struct packed {
		logic [KEY_BYTES-1:0][7:0] key;
		logic [4:0]                key_len;
		mode_t                     mode;
		logic                      icase;
	} cfg_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic icase);
		fold = (icase && c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		is_word = (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
			(c >= 8'd97 && c <= 8'd122) || (c == CHAR_US);
	endfunction

endpackage

// ===== sv/line_keyword_matcher.sv =====
// Top level of the line keyword matcher: configuration registers and block wiring.
//
// Text enters one byte per request on the in channel (in_valid, in_ready,
// in_data); a byte of 10 ends a line and end_of_data closes the text, so the
// next byte starts over at line 1. Each completed line gives one request on
// the out channel with its line number, saturating length and match flag.
// The keyword, its length, the match mode and case folding are written on
// the cfg channel, which is always ready; write it only while no byte or
// line result is still in flight.
// A byte accepted on the in channel reaches the back end through a two-entry
// queue; a result it closes is held in the output register behind out_valid.
// Throughput is one byte per cycle while the receiver keeps up: the whole
// keyword window is compared in parallel each cycle in the back end.
// When the receiver stalls, the output register holds its result, the back
// end stops and the queue absorbs up to two more bytes before in_ready drops.
// Reset clears the configuration to zero and starts at line 1 with an empty
// line; no clearing pass is needed.
module line_keyword_matcher import lkm_pkg::*; #(
	parameter int unsigned KEY_MAX = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers, as written by software.
	logic [CFG_W-1:0] key_lo_q;
	logic [CFG_W-1:0] key_hi_q;
	logic [4:0]       key_len_q;
	logic [1:0]       mode_raw_q;
	logic             icase_q;
	cfg_t             cfg;

	logic push_valid;
	logic push_ready;
	cls_t push_item;
	logic pop_valid;
	logic pop_ready;
	cls_t pop_item;

	// Register writes never stall.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q   <= '0;
			key_hi_q   <= '0;
			key_len_q  <= '0;
			mode_raw_q <= '0;
			icase_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY_LO:  key_lo_q   <= cfg_data;
				REG_KEY_HI:  key_hi_q   <= cfg_data;
				REG_KEY_LEN: key_len_q  <= cfg_data[4:0];
				REG_MODE:    mode_raw_q <= cfg_data[1:0];
				REG_ICASE:   icase_q    <= cfg_data[0];
				default: ; // Writes to unused indexes are dropped.
			endcase
		end
	end

	// Keyword byte 0 sits in the low bits of the low register, byte 8 in the
	// low bits of the high register. The unused mode code behaves as whole line.
	always_comb begin
		cfg.key     = {key_hi_q, key_lo_q};
		cfg.key_len = key_len_q;
		cfg.icase   = icase_q;
		unique case (mode_raw_q)
			MODE_SUBSTR: cfg.mode = MODE_SUBSTR;
			MODE_WORD:   cfg.mode = MODE_WORD;
			default:     cfg.mode = MODE_LINE;
		endcase
	end

	// Front end: takes text bytes and tags newline, last and word bytes.
	lkm_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// The queue lets the front keep taking bytes while the back waits on out_ready.
	lkm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Back end: line state, window compare and the output register.
	lkm_back #(
		.KEY_MAX (KEY_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== sv/lkm_front.sv =====
// Front end: accepts text bytes and classifies them for the back end.
module lkm_front import lkm_pkg::*; (
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic push_valid,
	input  logic push_ready,
	output cls_t push_item
);

	always_comb begin
		push_valid          = in_valid;
		in_ready            = push_ready;
		push_item.text_byte = in_data.text_byte;
		push_item.last      = in_data.end_of_data;
		push_item.is_nl     = (in_data.text_byte == CHAR_NL);
		push_item.is_word   = is_word(in_data.text_byte);
	end

endmodule

// ===== sv/lkm_queue.sv =====
// Short FIFO that decouples the classifying front from the matching back.
module lkm_queue import lkm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cls_t push_item,
	output logic pop_valid,
	input  logic pop_ready,
	output cls_t pop_item
);

	localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	cls_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push_fire;
	logic          pop_fire;

	assign push_ready = (cnt_q != CW'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/lkm_back.sv =====
// Back end: keeps the line state, compares the byte window and emits line results.
module lkm_back import lkm_pkg::*; #(
	parameter int unsigned KEY_MAX = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic pop_valid,
	output logic pop_ready,
	input  cls_t pop_item,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int unsigned KW = $clog2(KEY_MAX + 1);
	localparam int unsigned WD = KEY_MAX + 1;

	wslot_t           win_q [WD];
	wslot_t           win_n [WD];
	logic [NUM_W-1:0] line_cnt_q;
	logic [LEN_W-1:0] len_q;
	logic             found_q;
	logic             pend_q;
	logic             pfx_q;
	logic             out_valid_q;
	out_t             out_data_q;

	logic [KW-1:0]    k;
	logic             k_zero;
	logic             pend_start;
	logic             found_a;
	logic             pend_a;
	logic             pfx_a;
	logic [LEN_W-1:0] len_a;
	logic             tail_eq;
	logic             tail_hit;
	logic [3:0]       kpos;
	logic             found_c;
	logic             matched;
	logic             close;
	logic             pop_fire;
	logic [NUM_W-1:0] line_cnt_inc;

	assign k = (cfg.key_len > 5'(KEY_MAX)) ? KW'(KEY_MAX) : KW'(cfg.key_len);
	assign k_zero = (k == '0);

	always_comb begin
		win_n[0] = '{b: pop_item.text_byte, w: pop_item.is_word};
		for (int i = 1; i < WD; i++) begin
			win_n[i] = win_q[i-1];
		end
	end

	// Tail compare: the newest k bytes against the keyword, last byte first.
	always_comb begin
		tail_eq = 1'b1;
		kpos    = '0;
		for (int i = 0; i < KEY_MAX; i++) begin
			kpos = 4'(k) - 4'(i) - 4'd1;
			if (i < int'(k)) begin
				if (fold(win_n[i].b, cfg.icase) != fold(cfg.key[kpos], cfg.icase)) begin
					tail_eq = 1'b0;
				end
			end
		end
	end

	always_comb begin
		pend_start = pend_q || (len_q == '0 && cfg.mode == MODE_WORD && k_zero);
		found_a    = found_q;
		pend_a     = pend_q;
		pfx_a      = pfx_q;
		len_a      = len_q;
		tail_hit   = 1'b0;
		if (!pop_item.is_nl) begin
			found_a = found_q || (pend_start && !pop_item.is_word);
			pend_a  = 1'b0;
			if (len_q < LEN_W'(k) &&
				fold(pop_item.text_byte, cfg.icase) !=
				fold(cfg.key[len_q[3:0]], cfg.icase)) begin
				pfx_a = 1'b0;
			end
			len_a    = (len_q == '1) ? len_q : len_q + 1'b1;
			tail_hit = (len_a >= LEN_W'(k)) && tail_eq;
			if (tail_hit) begin
				if (cfg.mode == MODE_SUBSTR) begin
					found_a = 1'b1;
				end else if (cfg.mode == MODE_WORD) begin
					// A line edge on the left counts as a non-word neighbor.
					pend_a = (len_a > LEN_W'(k)) ? !win_n[k].w : 1'b1;
				end
			end
		end
		found_c = found_a || (cfg.mode == MODE_SUBSTR && k_zero) ||
			(cfg.mode == MODE_WORD && ((k_zero && len_a == '0) || pend_a));
		matched = (cfg.mode == MODE_LINE) ? (pfx_a && len_a == LEN_W'(k)) : found_c;
		close   = pop_item.is_nl || pop_item.last;
	end

	assign pop_ready    = !out_valid_q || out_ready;
	assign pop_fire     = pop_valid && pop_ready;
	assign line_cnt_inc = (line_cnt_q == '1) ? line_cnt_q : line_cnt_q + 1'b1;
	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;

	always_ff @(posedge clk) begin
		if (pop_fire && !pop_item.is_nl) begin
			for (int i = 0; i < WD; i++) begin
				win_q[i] <= win_n[i];
			end
		end
		if (pop_fire && close) begin
			out_data_q.line_number  <= line_cnt_q;
			out_data_q.line_length  <= len_a;
			out_data_q.line_matched <= matched;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cnt_q  <= NUM_W'(1);
			len_q       <= '0;
			found_q     <= 1'b0;
			pend_q      <= 1'b0;
			pfx_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_fire) begin
				if (close) begin
					line_cnt_q <= pop_item.last ? NUM_W'(1) : line_cnt_inc;
					len_q      <= '0;
					found_q    <= 1'b0;
					pend_q     <= 1'b0;
					pfx_q      <= 1'b1;
				end else begin
					len_q      <= len_a;
					found_q    <= found_a;
					pend_q     <= pend_a;
					pfx_q      <= pfx_a;
				end
			end
			if (pop_fire && close) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/lkm_checker.sv =====
// Port-level checker for the line keyword matcher and its bind.
`include "line_keyword_matcher_macros.svh"

module lkm_checker import lkm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// A stalled result stays in place.
	`LKM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// Line numbers start at one and saturate, so zero never shows.
	`LKM_ASSERT_SAME(a_num_nonzero, clk, arst_n, out_valid, out_data.line_number != '0)

	// Back-pressure only builds up from accepted bytes.
	`LKM_ASSERT_SAME(a_ready_drop, clk, arst_n, $fell(in_ready), $past(in_valid && in_ready))

	// A receiver that took results in the last cycle keeps the input open.
	`LKM_ASSERT_SAME(a_keeps_up, clk, arst_n, $past(out_ready), in_ready)

endmodule

bind line_keyword_matcher lkm_checker u_lkm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
